// ===== design/eea_pkg.sv =====
// Shared constants and types for the entropy estimate accumulator.
package eea_pkg;

    // Pool size in bits and the derating applied to every credit
    localparam int POOL_BITS   = 5120;
    localparam int DERATE_BITS = 2;

    // Field and state widths
    localparam int DELTA_W = 32;
    localparam int WBITS_W = 16;
    localparam int COUNT_W = 13;
    localparam int N_W     = 5;
    localparam int FRAC_W  = 32;

    // Whole bits credited for a delta whose leading one sits at bit 31
    localparam int N_BASE = 31 - DERATE_BITS;

    // Deltas below this value credit nothing
    localparam logic [DELTA_W:0] SMALL_LIMIT = (DELTA_W + 1)'(1) << DERATE_BITS;

    localparam logic [COUNT_W-1:0] POOL_COUNT = COUNT_W'(POOL_BITS);

    typedef enum logic [0:0] {
        OP_ADD      = 1'b0,
        OP_WITHDRAW = 1'b1
    } op_t;

    // Normalized delta handed to the credit logic
    typedef struct packed {
        logic                below_min;
        logic [N_W-1:0]      n_base;
        logic [FRAC_W-1:0]   mant;
    } norm_t;

endpackage

// ===== design/eea_norm.sv =====
// Leading-one search and mantissa extraction for a timing delta.
module eea_norm
(
    input  logic [eea_pkg::DELTA_W-1:0] delta,
    output eea_pkg::norm_t              norm
);

    logic [eea_pkg::DELTA_W-1:0] v;
    logic [4:0]                  lz;

    // Binary search for the leading one, shifting it up to bit 31
    always_comb
    begin
        v  = delta;
        lz = '0;
        if (v[31:16] == 16'h0)
        begin
            lz[4] = 1'b1;
            v     = v << 16;
        end
        if (v[31:24] == 8'h0)
        begin
            lz[3] = 1'b1;
            v     = v << 8;
        end
        if (v[31:28] == 4'h0)
        begin
            lz[2] = 1'b1;
            v     = v << 4;
        end
        if (v[31:30] == 2'h0)
        begin
            lz[1] = 1'b1;
            v     = v << 2;
        end
        if (v[31] == 1'b0)
        begin
            lz[0] = 1'b1;
            v     = v << 1;
        end
    end

    // Drop the leading one to form the 0.32 mantissa
    always_comb
    begin
        norm.below_min = ({1'b0, delta} < eea_pkg::SMALL_LIMIT);
        norm.n_base    = eea_pkg::N_W'(eea_pkg::N_BASE) - lz;
        norm.mant      = {v[30:0], 1'b0};
    end

endmodule

// ===== design/eea_credit.sv =====
// Fraction update: z = x + y + hi32(x*y) with carries folded into whole bits.
module eea_credit
(
    input  logic [eea_pkg::FRAC_W-1:0] frac,
    input  eea_pkg::norm_t             norm,
    output logic [eea_pkg::FRAC_W-1:0] frac_out,
    output logic [eea_pkg::N_W-1:0]    n
);

    logic [2*eea_pkg::FRAC_W-1:0] prod;
    logic [eea_pkg::FRAC_W:0]     sum1;
    logic [eea_pkg::FRAC_W:0]     sum2;
    logic                         c1;
    logic                         c2;

    // High half of the exact product, then two carry-tracked adds
    always_comb
    begin
        prod = {32'h0, frac} * {32'h0, norm.mant};
        sum1 = {1'b0, frac} + {1'b0, prod[63:32]};
        sum2 = {1'b0, sum1[31:0]} + {1'b0, norm.mant};
        c1   = sum1[32];
        c2   = sum2[32];
    end

    // Fold any carry into one more whole bit and halve the fraction
    always_comb
    begin
        if (c1 || c2)
        begin
            frac_out = {c1 & c2, sum2[31:1]};
            n        = norm.n_base + eea_pkg::N_W'(1);
        end
        else
        begin
            frac_out = sum2[31:0];
            n        = norm.n_base;
        end
    end

endmodule

// ===== design/entropy_estimate_accumulator_core.sv =====
// Top level: input register, estimate state and result register.
//
//  channel | handshake           | word
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_ready | operation, delta, withdraw_bits
//  out     | out_valid/out_ready | bits_added, entropy_level, inflow_level
//
// One word per cycle sustained while out_ready holds; a word's result is
// offered after it passes the input register, then the result register.
// The estimate state updates in the same cycle the result register loads;
// the multiply and adds between them set the cycle time.
// rst_n clears the estimate to zero and empties both registers.
// A stalled output holds its result; the input register still takes a word
// while it is empty or the result register is free or being drained.
module entropy_estimate_accumulator_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [0:0]                    operation,
    input  logic [eea_pkg::DELTA_W-1:0]   delta,
    input  logic [eea_pkg::WBITS_W-1:0]   withdraw_bits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [eea_pkg::N_W-1:0]       bits_added,
    output logic [eea_pkg::COUNT_W-1:0]   entropy_level,
    output logic [eea_pkg::COUNT_W-1:0]   inflow_level
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    eea_pkg::op_t                  s1_op_reg;
    logic [eea_pkg::DELTA_W-1:0]   s1_delta_reg;
    logic [eea_pkg::WBITS_W-1:0]   s1_wbits_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [eea_pkg::N_W-1:0]       out_bits_reg;
    logic [eea_pkg::N_W-1:0]       out_bits_next;

    logic [eea_pkg::COUNT_W-1:0]   count_reg;
    logic [eea_pkg::COUNT_W-1:0]   count_next;
    logic [eea_pkg::FRAC_W-1:0]    frac_reg;
    logic [eea_pkg::FRAC_W-1:0]    frac_next;
    logic [eea_pkg::COUNT_W-1:0]   inflow_reg;
    logic [eea_pkg::COUNT_W-1:0]   inflow_next;
    logic [eea_pkg::COUNT_W-1:0]   out_count_reg;
    logic [eea_pkg::COUNT_W-1:0]   out_inflow_reg;

    logic                          in_accept;
    logic                          advance;

    eea_pkg::norm_t                norm;
    logic [eea_pkg::FRAC_W-1:0]    credit_frac;
    logic [eea_pkg::N_W-1:0]       credit_n;
    logic [eea_pkg::COUNT_W:0]     count_sum;
    logic [eea_pkg::COUNT_W:0]     inflow_sum;

    // Handshake: stage one moves on whenever the result register is free
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    eea_norm u_norm
    (
        .delta (s1_delta_reg),
        .norm  (norm)
    );

    eea_credit u_credit
    (
        .frac     (frac_reg),
        .norm     (norm),
        .frac_out (credit_frac),
        .n        (credit_n)
    );

    // Compute the next estimate for the word in stage one
    always_comb
    begin
        count_sum     = {1'b0, count_reg} + (eea_pkg::COUNT_W + 1)'(credit_n);
        inflow_sum    = {1'b0, inflow_reg} + (eea_pkg::COUNT_W + 1)'(credit_n);
        count_next    = count_reg;
        frac_next     = frac_reg;
        inflow_next   = inflow_reg;
        out_bits_next = '0;
        case (s1_op_reg)
            eea_pkg::OP_ADD:
            begin
                if (!norm.below_min)
                begin
                    out_bits_next = credit_n;
                    if (count_sum >= {1'b0, eea_pkg::POOL_COUNT})
                    begin
                        count_next = eea_pkg::POOL_COUNT;
                        frac_next  = '0;
                    end
                    else
                    begin
                        count_next = count_sum[eea_pkg::COUNT_W-1:0];
                        frac_next  = credit_frac;
                    end
                    if (inflow_sum >= {1'b0, eea_pkg::POOL_COUNT})
                    begin
                        inflow_next = eea_pkg::POOL_COUNT;
                    end
                    else
                    begin
                        inflow_next = inflow_sum[eea_pkg::COUNT_W-1:0];
                    end
                end
            end
            eea_pkg::OP_WITHDRAW:
            begin
                if ({{(eea_pkg::WBITS_W - eea_pkg::COUNT_W){1'b0}}, count_reg}
                    >= s1_wbits_reg)
                begin
                    count_next = count_reg - s1_wbits_reg[eea_pkg::COUNT_W-1:0];
                end
                else
                begin
                    count_next = '0;
                    frac_next  = '0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Control and estimate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            frac_reg      <= '0;
            inflow_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                count_reg  <= count_next;
                frac_reg   <= frac_next;
                inflow_reg <= inflow_next;
            end
        end
    end

    // Capture the input word and hold the result word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg    <= eea_pkg::op_t'(operation);
            s1_delta_reg <= delta;
            s1_wbits_reg <= withdraw_bits;
        end
        if (advance)
        begin
            out_bits_reg   <= out_bits_next;
            out_count_reg  <= count_next;
            out_inflow_reg <= inflow_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bits_added    = out_bits_reg;
    assign entropy_level = out_count_reg;
    assign inflow_level  = out_inflow_reg;

    // Counts never pass the pool size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= eea_pkg::POOL_COUNT) && (inflow_reg <= eea_pkg::POOL_COUNT))
        else $error("estimate count beyond pool size");

    // A full pool carries no fraction
    a_full_no_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == eea_pkg::POOL_COUNT) |-> (frac_reg == '0))
        else $error("fraction left set on a full pool");

    // Inflow only grows
    a_inflow_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (inflow_reg >= $past(inflow_reg)))
        else $error("inflow count decreased");

    // State changes only when a word passes to the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(count_reg) && $stable(frac_reg) && $stable(inflow_reg)))
        else $error("estimate changed without a word");

endmodule
